FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions used in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, switched off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/mie_pkg.sv
// ---------------------------------------------------------------------------
// mie_pkg
// Types and constants of the MessagePack item encoder.
// ---------------------------------------------------------------------------
package mie_pkg;

  typedef enum logic [3:0] {
    OP_NIL   = 4'd0,
    OP_BOOL  = 4'd1,
    OP_UINT  = 4'd2,
    OP_INT   = 4'd3,
    OP_F32   = 4'd4,
    OP_F64   = 4'd5,
    OP_ARRAY = 4'd6,
    OP_MAP   = 4'd7,
    OP_STR   = 4'd8,
    OP_BIN   = 4'd9,
    OP_EXT   = 4'd10,
    OP_RAW   = 4'd11
  } opcode_t;

  localparam int unsigned StageDepth = 9;
  localparam int unsigned StageBits  = StageDepth * 8;
  localparam int unsigned LenBits    = 4;

  localparam logic [7:0] TAG_NIL      = 8'hc0;
  localparam logic [7:0] TAG_FALSE    = 8'hc2;
  localparam logic [7:0] TAG_BIN8     = 8'hc4;
  localparam logic [7:0] TAG_BIN16    = 8'hc5;
  localparam logic [7:0] TAG_BIN32    = 8'hc6;
  localparam logic [7:0] TAG_EXT8     = 8'hc7;
  localparam logic [7:0] TAG_EXT16    = 8'hc8;
  localparam logic [7:0] TAG_EXT32    = 8'hc9;
  localparam logic [7:0] TAG_FLOAT32  = 8'hca;
  localparam logic [7:0] TAG_FLOAT64  = 8'hcb;
  localparam logic [7:0] TAG_UINT8    = 8'hcc;
  localparam logic [7:0] TAG_UINT16   = 8'hcd;
  localparam logic [7:0] TAG_UINT32   = 8'hce;
  localparam logic [7:0] TAG_UINT64   = 8'hcf;
  localparam logic [7:0] TAG_INT8     = 8'hd0;
  localparam logic [7:0] TAG_INT16    = 8'hd1;
  localparam logic [7:0] TAG_INT32    = 8'hd2;
  localparam logic [7:0] TAG_INT64    = 8'hd3;
  localparam logic [7:0] TAG_FIXEXT1  = 8'hd4;
  localparam logic [7:0] TAG_FIXEXT2  = 8'hd5;
  localparam logic [7:0] TAG_FIXEXT4  = 8'hd6;
  localparam logic [7:0] TAG_FIXEXT8  = 8'hd7;
  localparam logic [7:0] TAG_FIXEXT16 = 8'hd8;
  localparam logic [7:0] TAG_STR8     = 8'hd9;
  localparam logic [7:0] TAG_STR16    = 8'hda;
  localparam logic [7:0] TAG_STR32    = 8'hdb;
  localparam logic [7:0] TAG_ARRAY16  = 8'hdc;
  localparam logic [7:0] TAG_ARRAY32  = 8'hdd;
  localparam logic [7:0] TAG_MAP16    = 8'hde;
  localparam logic [7:0] TAG_MAP32    = 8'hdf;
  localparam logic [7:0] BASE_FIXARRAY = 8'h90;
  localparam logic [7:0] BASE_FIXMAP   = 8'h80;
  localparam logic [7:0] BASE_FIXSTR   = 8'ha0;

  typedef struct packed {
    logic [StageBits-1:0] bytes;
    logic [LenBits-1:0]   len;
  } enc_t;

endpackage

FILE: rtl/mie_item_if.sv
// ---------------------------------------------------------------------------
// mie_item_if
// Input channel: one item to encode per beat.
// ---------------------------------------------------------------------------
interface mie_item_if;
  logic              valid;
  logic              ready;
  logic [3:0]        opcode;
  logic [63:0]       value_word;
  logic signed [7:0] ext_type;

  modport source (output valid, output opcode, output value_word, output ext_type,
                  input ready);
  modport sink (input valid, input opcode, input value_word, input ext_type,
                output ready);
endinterface

FILE: rtl/mie_byte_if.sv
// ---------------------------------------------------------------------------
// mie_byte_if
// Output channel: one encoded byte per beat.
// ---------------------------------------------------------------------------
interface mie_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

FILE: rtl/mie_encode.sv
// ---------------------------------------------------------------------------
// mie_encode
// Maps one item to its MessagePack bytes, left aligned, with the byte count.
// ---------------------------------------------------------------------------
module mie_encode (
  input  logic [3:0]        opcode,
  input  logic [63:0]       value_word,
  input  logic signed [7:0] ext_type,
  output mie_pkg::enc_t     enc
);

  logic [63:0] v;
  logic [31:0] n;
  logic [7:0]  t;

  assign v = value_word;
  assign n = value_word[31:0];
  assign t = ext_type;

  always_comb begin
    enc.bytes = '0;
    enc.len   = '0;
    case (opcode)
      mie_pkg::OP_NIL: begin
        enc.bytes = {mie_pkg::TAG_NIL, 64'h0};
        enc.len   = 4'd1;
      end
      mie_pkg::OP_BOOL: begin
        enc.bytes = {mie_pkg::TAG_FALSE | {7'h0, v[0]}, 64'h0};
        enc.len   = 4'd1;
      end
      mie_pkg::OP_UINT, mie_pkg::OP_INT: begin
        if (opcode == mie_pkg::OP_INT && v[63]) begin
          if (&v[63:5]) begin
            enc.bytes = {v[7:0], 64'h0};
            enc.len   = 4'd1;
          end else if (&v[63:7]) begin
            enc.bytes = {mie_pkg::TAG_INT8, v[7:0], 56'h0};
            enc.len   = 4'd2;
          end else if (&v[63:15]) begin
            enc.bytes = {mie_pkg::TAG_INT16, v[15:0], 48'h0};
            enc.len   = 4'd3;
          end else if (&v[63:31]) begin
            enc.bytes = {mie_pkg::TAG_INT32, v[31:0], 32'h0};
            enc.len   = 4'd5;
          end else begin
            enc.bytes = {mie_pkg::TAG_INT64, v};
            enc.len   = 4'd9;
          end
        end else if (v[63:7] == '0) begin
          enc.bytes = {v[7:0], 64'h0};
          enc.len   = 4'd1;
        end else if (v[63:8] == '0) begin
          enc.bytes = {mie_pkg::TAG_UINT8, v[7:0], 56'h0};
          enc.len   = 4'd2;
        end else if (v[63:16] == '0) begin
          enc.bytes = {mie_pkg::TAG_UINT16, v[15:0], 48'h0};
          enc.len   = 4'd3;
        end else if (v[63:32] == '0) begin
          enc.bytes = {mie_pkg::TAG_UINT32, v[31:0], 32'h0};
          enc.len   = 4'd5;
        end else begin
          enc.bytes = {mie_pkg::TAG_UINT64, v};
          enc.len   = 4'd9;
        end
      end
      mie_pkg::OP_F32: begin
        enc.bytes = {mie_pkg::TAG_FLOAT32, v[31:0], 32'h0};
        enc.len   = 4'd5;
      end
      mie_pkg::OP_F64: begin
        enc.bytes = {mie_pkg::TAG_FLOAT64, v};
        enc.len   = 4'd9;
      end
      mie_pkg::OP_ARRAY, mie_pkg::OP_MAP: begin
        if (n[31:4] == '0) begin
          enc.bytes = {((opcode == mie_pkg::OP_ARRAY) ? mie_pkg::BASE_FIXARRAY
                                                       : mie_pkg::BASE_FIXMAP)
                       | {4'h0, n[3:0]}, 64'h0};
          enc.len   = 4'd1;
        end else if (n[31:16] == '0) begin
          enc.bytes = {((opcode == mie_pkg::OP_ARRAY) ? mie_pkg::TAG_ARRAY16
                                                       : mie_pkg::TAG_MAP16),
                       n[15:0], 48'h0};
          enc.len   = 4'd3;
        end else begin
          enc.bytes = {((opcode == mie_pkg::OP_ARRAY) ? mie_pkg::TAG_ARRAY32
                                                       : mie_pkg::TAG_MAP32),
                       n, 32'h0};
          enc.len   = 4'd5;
        end
      end
      mie_pkg::OP_STR: begin
        if (n[31:5] == '0) begin
          enc.bytes = {mie_pkg::BASE_FIXSTR | {3'h0, n[4:0]}, 64'h0};
          enc.len   = 4'd1;
        end else if (n[31:8] == '0) begin
          enc.bytes = {mie_pkg::TAG_STR8, n[7:0], 56'h0};
          enc.len   = 4'd2;
        end else if (n[31:16] == '0) begin
          enc.bytes = {mie_pkg::TAG_STR16, n[15:0], 48'h0};
          enc.len   = 4'd3;
        end else begin
          enc.bytes = {mie_pkg::TAG_STR32, n, 32'h0};
          enc.len   = 4'd5;
        end
      end
      mie_pkg::OP_BIN: begin
        if (n[31:8] == '0) begin
          enc.bytes = {mie_pkg::TAG_BIN8, n[7:0], 56'h0};
          enc.len   = 4'd2;
        end else if (n[31:16] == '0) begin
          enc.bytes = {mie_pkg::TAG_BIN16, n[15:0], 48'h0};
          enc.len   = 4'd3;
        end else begin
          enc.bytes = {mie_pkg::TAG_BIN32, n, 32'h0};
          enc.len   = 4'd5;
        end
      end
      mie_pkg::OP_EXT: begin
        if (n == 32'd1) begin
          enc.bytes = {mie_pkg::TAG_FIXEXT1, t, 56'h0};
          enc.len   = 4'd2;
        end else if (n == 32'd2) begin
          enc.bytes = {mie_pkg::TAG_FIXEXT2, t, 56'h0};
          enc.len   = 4'd2;
        end else if (n == 32'd4) begin
          enc.bytes = {mie_pkg::TAG_FIXEXT4, t, 56'h0};
          enc.len   = 4'd2;
        end else if (n == 32'd8) begin
          enc.bytes = {mie_pkg::TAG_FIXEXT8, t, 56'h0};
          enc.len   = 4'd2;
        end else if (n == 32'd16) begin
          enc.bytes = {mie_pkg::TAG_FIXEXT16, t, 56'h0};
          enc.len   = 4'd2;
        end else if (n[31:8] == '0) begin
          enc.bytes = {mie_pkg::TAG_EXT8, n[7:0], t, 48'h0};
          enc.len   = 4'd3;
        end else if (n[31:16] == '0) begin
          enc.bytes = {mie_pkg::TAG_EXT16, n[15:0], t, 40'h0};
          enc.len   = 4'd4;
        end else begin
          enc.bytes = {mie_pkg::TAG_EXT32, n, t, 24'h0};
          enc.len   = 4'd6;
        end
      end
      mie_pkg::OP_RAW: begin
        enc.bytes = {v[7:0], 64'h0};
        enc.len   = 4'd1;
      end
      default: begin
        enc.bytes = '0;
        enc.len   = '0;
      end
    endcase
  end

endmodule

FILE: rtl/msgpack_item_encoder.sv
// ---------------------------------------------------------------------------
// msgpack_item_encoder
// Encodes one MessagePack item per input beat into a stream of byte beats.
// ---------------------------------------------------------------------------
// An item is encoded in the cycle it is accepted and its bytes leave one per
// output beat, first byte in the cycle after acceptance, with last_byte set on
// the final one. An item that encodes to N bytes (1 to 9) therefore occupies
// the byte port for N beats; the next item is taken in the same cycle as the
// final byte of the previous one, so single-byte items flow at one per cycle
// while encoded.ready holds. Unused kind codes are accepted and produce no bytes.
`include "assert_macros.svh"

module msgpack_item_encoder (
  input logic        clk,
  input logic        rst,
  mie_item_if.sink   item,
  mie_byte_if.source encoded
);

  mie_pkg::enc_t                     enc;
  logic [mie_pkg::StageBits-1:0]     staged;
  logic [mie_pkg::LenBits-1:0]       remaining;
  logic                              item_fire;
  logic                              byte_fire;

  mie_encode u_encode (
    .opcode     (item.opcode),
    .value_word (item.value_word),
    .ext_type   (item.ext_type),
    .enc        (enc)
  );

  assign byte_fire  = encoded.valid && encoded.ready;
  assign item.ready = (remaining == '0) || ((remaining == 4'd1) && encoded.ready);
  assign item_fire  = item.valid && item.ready;

  assign encoded.valid     = (remaining != '0);
  assign encoded.out_byte  = staged[mie_pkg::StageBits-1 -: 8];
  assign encoded.last_byte = (remaining == 4'd1);

  always_ff @(posedge clk) begin
    if (item_fire) begin
      staged <= enc.bytes;
    end else if (byte_fire) begin
      staged <= {staged[mie_pkg::StageBits-9:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (item_fire) begin
      remaining <= enc.len;
    end else if (byte_fire) begin
      remaining <= remaining - 4'd1;
    end
  end

  `ASSERT_CLK_RST(a_item_only_at_end, clk, rst, item_fire |-> (!encoded.valid || (encoded.last_byte && encoded.ready)), "item accepted while bytes of the previous item are still pending")
  `ASSERT_CLK_RST(a_no_gap_in_item, clk, rst, (byte_fire && !encoded.last_byte) |=> encoded.valid, "byte stream of an item ended without a last byte")
  `ASSERT_CLK(a_quiet_after_reset, clk, $past(rst) |-> !encoded.valid, "byte beat offered right after reset")

endmodule

FILE: tb/sv/mie_tb_pkg.sv
// ---------------------------------------------------------------------------
// mie_tb_pkg
// Expected-byte tracking for the MessagePack item encoder testbench. Each
// accepted item is encoded in software to its wire bytes, and the bytes that
// leave the block are checked in order against them.
// ---------------------------------------------------------------------------
package mie_tb_pkg;
  import mie_pkg::*;

  localparam logic [3:0] OP_FIRST_UNUSED = 4'd12;
  localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } wire_beat_t;

  class wire_byte_checker;
    wire_beat_t  beats_due[$];
    logic [7:0]  staged[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    function int unsigned pending();
      return beats_due.size();
    endfunction

    function void stage_be(logic [63:0] v, int nbytes);
      for (int i = nbytes - 1; i >= 0; i--) begin
        staged.push_back(v[8*i +: 8]);
      end
    endfunction

    function void stage_uint(logic [63:0] v);
      if (v <= 64'h7f) begin
        stage_be(v, 1);
      end else if (v <= 64'hff) begin
        staged.push_back(TAG_UINT8);
        stage_be(v, 1);
      end else if (v <= 64'hffff) begin
        staged.push_back(TAG_UINT16);
        stage_be(v, 2);
      end else if (v <= 64'hffff_ffff) begin
        staged.push_back(TAG_UINT32);
        stage_be(v, 4);
      end else begin
        staged.push_back(TAG_UINT64);
        stage_be(v, 8);
      end
    endfunction

    function void stage_int(logic [63:0] v);
      if (!v[63]) begin
        stage_uint(v);
      end else if (v >= 64'hffff_ffff_ffff_ffe0) begin
        stage_be(v, 1);
      end else if (v >= 64'hffff_ffff_ffff_ff80) begin
        staged.push_back(TAG_INT8);
        stage_be(v, 1);
      end else if (v >= 64'hffff_ffff_ffff_8000) begin
        staged.push_back(TAG_INT16);
        stage_be(v, 2);
      end else if (v >= 64'hffff_ffff_8000_0000) begin
        staged.push_back(TAG_INT32);
        stage_be(v, 4);
      end else begin
        staged.push_back(TAG_INT64);
        stage_be(v, 8);
      end
    endfunction

    function void stage_header(logic [7:0] fix_base, logic [7:0] tag16, logic [7:0] tag32,
                               logic [31:0] n);
      if (n <= 32'd15) begin
        staged.push_back(fix_base | n[7:0]);
      end else if (n <= 32'hffff) begin
        staged.push_back(tag16);
        stage_be({32'd0, n}, 2);
      end else begin
        staged.push_back(tag32);
        stage_be({32'd0, n}, 4);
      end
    endfunction

    function void stage_str(logic [31:0] n);
      if (n <= 32'd31) begin
        staged.push_back(BASE_FIXSTR | n[7:0]);
      end else if (n <= 32'hff) begin
        staged.push_back(TAG_STR8);
        stage_be({32'd0, n}, 1);
      end else if (n <= 32'hffff) begin
        staged.push_back(TAG_STR16);
        stage_be({32'd0, n}, 2);
      end else begin
        staged.push_back(TAG_STR32);
        stage_be({32'd0, n}, 4);
      end
    endfunction

    function void stage_bin(logic [31:0] n);
      if (n <= 32'hff) begin
        staged.push_back(TAG_BIN8);
        stage_be({32'd0, n}, 1);
      end else if (n <= 32'hffff) begin
        staged.push_back(TAG_BIN16);
        stage_be({32'd0, n}, 2);
      end else begin
        staged.push_back(TAG_BIN32);
        stage_be({32'd0, n}, 4);
      end
    endfunction

    // Fixed-size forms exist only for 1, 2, 4, 8 and 16 bytes; a zero length
    // falls through to ext8. The type byte always comes last.
    function void stage_ext(logic [7:0] ext_type, logic [31:0] n);
      case (n)
        32'd1:  staged.push_back(TAG_FIXEXT1);
        32'd2:  staged.push_back(TAG_FIXEXT2);
        32'd4:  staged.push_back(TAG_FIXEXT4);
        32'd8:  staged.push_back(TAG_FIXEXT8);
        32'd16: staged.push_back(TAG_FIXEXT16);
        default: begin
          if (n <= 32'hff) begin
            staged.push_back(TAG_EXT8);
            stage_be({32'd0, n}, 1);
          end else if (n <= 32'hffff) begin
            staged.push_back(TAG_EXT16);
            stage_be({32'd0, n}, 2);
          end else begin
            staged.push_back(TAG_EXT32);
            stage_be({32'd0, n}, 4);
          end
        end
      endcase
      staged.push_back(ext_type);
    endfunction

    function void note_item(logic [3:0] op, logic [63:0] v, logic [7:0] ext_type);
      wire_beat_t beat;
      staged.delete();
      case (op)
        OP_NIL:   staged.push_back(TAG_NIL);
        OP_BOOL:  staged.push_back(TAG_FALSE | {7'd0, v[0]});
        OP_UINT:  stage_uint(v);
        OP_INT:   stage_int(v);
        OP_F32: begin
          staged.push_back(TAG_FLOAT32);
          stage_be({32'd0, v[31:0]}, 4);
        end
        OP_F64: begin
          staged.push_back(TAG_FLOAT64);
          stage_be(v, 8);
        end
        OP_ARRAY: stage_header(BASE_FIXARRAY, TAG_ARRAY16, TAG_ARRAY32, v[31:0]);
        OP_MAP:   stage_header(BASE_FIXMAP, TAG_MAP16, TAG_MAP32, v[31:0]);
        OP_STR:   stage_str(v[31:0]);
        OP_BIN:   stage_bin(v[31:0]);
        OP_EXT:   stage_ext(ext_type, v[31:0]);
        OP_RAW:   staged.push_back(v[7:0]);
        default: ;
      endcase
      foreach (staged[k]) begin
        beat.value = staged[k];
        beat.last  = (k == staged.size() - 1);
        beats_due.push_back(beat);
      end
    endfunction

    function void check_byte(logic [7:0] value, logic last);
      wire_beat_t want;
      if (beats_due.size() == 0) begin
        $error("unexpected beat: out_byte 8'h%02h, last_byte %0b", value, last);
        failures++;
        return;
      end
      want = beats_due.pop_front();
      if (value !== want.value) begin
        $error("out_byte: expected 8'h%02h, got 8'h%02h", want.value, value);
        failures++;
      end
      if (last !== want.last) begin
        $error("last_byte: expected %0b, got %0b", want.last, last);
        failures++;
      end
    endfunction
  endclass

endpackage

FILE: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking testbench for the MessagePack item encoder. A directed set of
// items covers every kind and several boundaries between encoding forms, then
// random items with random gaps on the input and random stalls on the output
// follow, including at least one long output stall and at least one full drain.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mie_pkg::*;
  import mie_tb_pkg::*;

  localparam int unsigned RandomItems  = 220;
  localparam int unsigned ChokeCycles  = 300;
  localparam int unsigned SettleCycles = 20;

  logic clk = 1'b0;
  logic rst;
  bit   choke_sink = 1'b0;
  bit   steady = 1'b0;

  wire_byte_checker codec = new();

  mie_item_if item_ch();
  mie_byte_if byte_ch();

  msgpack_item_encoder dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .encoded (byte_ch)
  );

  always #6 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    int unsigned nbits;
    w = {$urandom(), $urandom()};
    nbits = $urandom_range(1, 64);
    case ($urandom_range(0, 3))
      0: w = w >> (64 - nbits);
      1: w = ~(w >> (64 - nbits));
      2: begin
        w = (64'd1 << $urandom_range(0, 63)) + 64'($urandom_range(0, 2)) - 64'd1;
        if ($urandom_range(0, 1) == 1) begin
          w = -w;
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_item(input logic [3:0] op, input logic [63:0] v, input logic [7:0] t);
    int unsigned gap;
    item_ch.valid      <= 1'b1;
    item_ch.opcode     <= op;
    item_ch.value_word <= v;
    item_ch.ext_type   <= t;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    codec.note_item(op, v, t);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (codec.pending() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      codec.check_byte(byte_ch.out_byte, byte_ch.last_byte);
    end
  end

  initial begin
    int unsigned on_len;
    int unsigned off_len;
    forever begin
      if (choke_sink) begin
        byte_ch.ready <= 1'b0;
        repeat (ChokeCycles) @(posedge clk);
        choke_sink = 1'b0;
      end
      on_len = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      byte_ch.ready <= 1'b1;
      repeat (on_len) begin
        if (choke_sink) break;
        @(posedge clk);
      end
      off_len = choke_sink ? 0 : pick_gap();
      if (off_len > 0) begin
        byte_ch.ready <= 1'b0;
        repeat (off_len) @(posedge clk);
      end
    end
  end

  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [3:0]  op;
    logic [63:0] v;
    logic [7:0]  t;
    int unsigned used;
    int unsigned k;

    rst                <= 1'b1;
    item_ch.valid      <= 1'b0;
    item_ch.opcode     <= OP_NIL;
    item_ch.value_word <= 64'd0;
    item_ch.ext_type   <= 8'sd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(OP_NIL,   64'd0,                  8'h5a);
    send_item(OP_BOOL,  64'hffff_ffff_ffff_fffe, 8'h00);
    send_item(OP_BOOL,  64'h0000_0000_0000_0001, 8'hff);
    send_item(OP_UINT,  64'h7f,                 8'h00);
    send_item(OP_UINT,  64'h80,                 8'h00);
    send_item(OP_UINT,  64'hffff_ffff_ffff_ffff, 8'h00);
    send_item(OP_INT,   64'hffff_ffff_ffff_ffe0, 8'h00);
    send_item(OP_INT,   64'hffff_ffff_ffff_ff7f, 8'h00);
    send_item(OP_INT,   64'h8000_0000_0000_0000, 8'h00);
    send_item(OP_F32,   64'hdead_beef_3f80_0000, 8'h00);
    send_item(OP_F64,   64'h7ff0_0000_0000_0001, 8'h00);
    send_item(OP_ARRAY, 64'hffff_ffff_0000_000f, 8'h00);
    send_item(OP_MAP,   64'h0000_0000_ffff_ffff, 8'h00);
    send_item(OP_STR,   64'd31,                 8'h00);
    send_item(OP_STR,   64'd32,                 8'h00);
    send_item(OP_STR,   64'd255,                8'h00);
    send_item(OP_BIN,   64'd0,                  8'h00);
    send_item(OP_EXT,   64'd0,                  8'h80);
    send_item(OP_EXT,   64'd16,                 8'h7f);
    send_item(OP_EXT,   64'd17,                 8'h01);
    send_item(OP_EXT,   64'h0001_0000,          8'hff);
    send_item(OP_RAW,   64'hffff_ffff_ffff_ff00, 8'h00);
    send_item(OP_FIRST_UNUSED, 64'hffff_ffff_ffff_ffff, 8'hff);
    send_item(OP_LAST_UNUSED,  64'd0,           8'h00);
    wait_drained();

    used = 0;
    while (used < RandomItems) begin
      if (used % 40 == 0) begin
        steady = ($urandom_range(0, 2) == 0);
      end
      if (used == 100) begin
        choke_sink = 1'b1;
        steady = 1'b1;
      end
      if (used == 180) begin
        wait_drained();
      end
      if ($urandom_range(0, 99) < 6) begin
        op = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      end else begin
        op = 4'($urandom_range(OP_NIL, OP_RAW));
        used++;
      end
      v = rand_word();
      t = 8'($urandom_range(0, 255));
      if (op != OP_UINT && op != OP_INT && op != OP_F64 && $urandom_range(0, 1) == 1) begin
        v[63:32] = $urandom();
      end
      if (op == OP_EXT && $urandom_range(0, 1) == 1) begin
        k = $urandom_range(0, 5);
        v[31:0] = (k == 0) ? 32'd0 : 32'd1 << (k - 1);
      end
      send_item(op, v, t);
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (codec.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
